// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion with an active-low reset that disables it
`define DSC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("crossover checker: assertion failed");

// shorthand for checkers on the block clock and reset
`define DSC_ASSERT_CLK(lbl, prop) `DSC_ASSERT(lbl, clk, arst_n, prop)

`endif

// ===== rtl/core/dsc_pkg.sv =====
// shared types and constants of the moving-average crossover detector
package dsc_pkg;

	localparam int MAX_PERIOD_DEF  = 256;
	localparam int PRICE_WIDTH_DEF = 32;

	localparam int CFG_WIDTH = 9;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_WIDTH-1:0] SHORT_PERIOD_RST = 9'd10;
	localparam logic [CFG_WIDTH-1:0] LONG_PERIOD_RST  = 9'd30;

	// result payload layout
	localparam int SUM_OUT_W    = 40;
	localparam int OUT_BUY_BIT  = 0;
	localparam int OUT_SELL_BIT = 1;
	localparam int OUT_SHORT_LO = 2;
	localparam int OUT_LONG_LO  = OUT_SHORT_LO + SUM_OUT_W;
	localparam int OUT_USED_W   = OUT_LONG_LO + SUM_OUT_W;
	localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_DATA_W - OUT_USED_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT_PERIOD,
		REG_LONG_PERIOD
	} cfg_reg_t;

	typedef enum logic [1:0] {
		REL_BELOW,
		REL_EQUAL,
		REL_ABOVE
	} rel_t;

	// per-item control decided when the item is accepted
	typedef struct packed {
		logic sub_short;
		logic sub_long;
		logic status;
	} step_ctrl_t;

endpackage

// ===== rtl/core/dsc_ring.sv =====
// price history ring: one write port, two registered read ports
module dsc_ring #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_a,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	// read returns the old contents when the same entry is written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

// ===== rtl/core/dsc_front.sv =====
// config registers, ring pointer, sample count and ring addressing
module dsc_front import dsc_pkg::*; #(
	parameter int MAX_PERIOD = MAX_PERIOD_DEF,
	parameter int AW         = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0] cfg_wdata,
	input  logic                 in_fire,
	output logic [AW-1:0]        wr_addr,
	output logic [AW-1:0]        rd_addr_short,
	output logic [AW-1:0]        rd_addr_long,
	output step_ctrl_t           ctrl,
	output logic                 restart,
	output logic [CFG_WIDTH-1:0] eff_short,
	output logic [CFG_WIDTH-1:0] eff_long
);

	logic [CFG_WIDTH-1:0] short_period_q;
	logic [CFG_WIDTH-1:0] long_period_q;
	logic [AW-1:0]        wp_q;
	logic [CFG_WIDTH-1:0] cnt_q;
	logic [CFG_WIDTH:0]   cnt_inc;
	logic [AW:0]          back_s;
	logic [AW:0]          back_l;

	assign restart = cfg_wr_en;

	// effective windows: long in 1..MAX_PERIOD, short in 1..long
	always_comb begin
		if (long_period_q == '0) begin
			eff_long = CFG_WIDTH'(1);
		end else if (32'(long_period_q) > 32'(MAX_PERIOD)) begin
			eff_long = CFG_WIDTH'(MAX_PERIOD);
		end else begin
			eff_long = long_period_q;
		end
		if (short_period_q == '0) begin
			eff_short = CFG_WIDTH'(1);
		end else if (short_period_q > eff_long) begin
			eff_short = eff_long;
		end else begin
			eff_short = short_period_q;
		end
	end

	// entry written n items ago, modulo the ring depth
	always_comb begin
		back_s = {1'b0, wp_q} + (AW+1)'(MAX_PERIOD) - (AW+1)'(eff_short);
		back_l = {1'b0, wp_q} + (AW+1)'(MAX_PERIOD) - (AW+1)'(eff_long);
		if (back_s >= (AW+1)'(MAX_PERIOD)) begin
			back_s = back_s - (AW+1)'(MAX_PERIOD);
		end
		if (back_l >= (AW+1)'(MAX_PERIOD)) begin
			back_l = back_l - (AW+1)'(MAX_PERIOD);
		end
	end

	assign rd_addr_short = back_s[AW-1:0];
	assign rd_addr_long  = back_l[AW-1:0];
	assign wr_addr       = wp_q;

	assign cnt_inc = {1'b0, cnt_q} + (CFG_WIDTH+1)'(1);

	always_comb begin
		ctrl.sub_short = cnt_q >= eff_short;
		ctrl.sub_long  = cnt_q >= eff_long;
		ctrl.status    = (cnt_q >= eff_long) || (cnt_inc >= {1'b0, eff_long});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_period_q <= SHORT_PERIOD_RST;
			long_period_q  <= LONG_PERIOD_RST;
			wp_q           <= '0;
			cnt_q          <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SHORT_PERIOD: short_period_q <= cfg_wdata;
				REG_LONG_PERIOD:  long_period_q  <= cfg_wdata;
			endcase
			cnt_q <= '0;
		end else if (in_fire) begin
			wp_q <= (wp_q == AW'(MAX_PERIOD - 1)) ? '0 : wp_q + AW'(1);
			if (cnt_q < eff_long) begin
				cnt_q <= cnt_inc[CFG_WIDTH-1:0];
			end
		end
	end

endmodule

// ===== rtl/core/dsc_sums.sv =====
// ring read stage and the running short and long window sums
module dsc_sums import dsc_pkg::*; #(
	parameter int PRICE_WIDTH = PRICE_WIDTH_DEF,
	parameter int SW          = 41
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   restart,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [PRICE_WIDTH-1:0] in_price,
	input  step_ctrl_t             in_ctrl,
	input  logic [PRICE_WIDTH-1:0] old_short,
	input  logic [PRICE_WIDTH-1:0] old_long,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_status,
	output logic [SW-1:0]          out_short_sum,
	output logic [SW-1:0]          out_long_sum
);

	logic                   v_s1;
	logic [PRICE_WIDTH-1:0] price_s1;
	step_ctrl_t             ctrl_s1;
	logic                   v_s2;
	logic                   status_s2;
	logic [SW-1:0]          short_sum_q;
	logic [SW-1:0]          long_sum_q;
	logic                   rdy_s2;
	logic                   move_s1;

	assign rdy_s2   = !v_s2 || out_ready;
	assign in_ready = !v_s1 || rdy_s2;
	assign move_s1  = v_s1 && rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			short_sum_q <= '0;
			long_sum_q  <= '0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (restart) begin
				short_sum_q <= '0;
				long_sum_q  <= '0;
			end else if (move_s1) begin
				// add the new price, drop the one leaving each window
				short_sum_q <= short_sum_q + SW'(price_s1)
					- (ctrl_s1.sub_short ? SW'(old_short) : '0);
				long_sum_q  <= long_sum_q + SW'(price_s1)
					- (ctrl_s1.sub_long ? SW'(old_long) : '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			price_s1 <= in_price;
			ctrl_s1  <= in_ctrl;
		end
		if (move_s1) begin
			status_s2 <= ctrl_s1.status;
		end
	end

	// the accumulators are the stage two payload
	assign out_valid     = v_s2;
	assign out_status    = status_s2;
	assign out_short_sum = short_sum_q;
	assign out_long_sum  = long_sum_q;

endmodule

// ===== rtl/core/dsc_cross.sv =====
// cross-multiplied average compare, crossing detection and result register
module dsc_cross import dsc_pkg::*; #(
	parameter int SW = 41
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 restart,
	input  logic [CFG_WIDTH-1:0] eff_short,
	input  logic [CFG_WIDTH-1:0] eff_long,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_status,
	input  logic [SW-1:0]        in_short_sum,
	input  logic [SW-1:0]        in_long_sum,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_status,
	output logic                 out_buy,
	output logic                 out_sell,
	output logic [SUM_OUT_W-1:0] out_short_sum,
	output logic [SUM_OUT_W-1:0] out_long_sum
);

	localparam int PROD_W = SW + CFG_WIDTH;

	logic                 v_s3;
	logic                 status_s3;
	logic [PROD_W-1:0]    prod_short_s3;
	logic [PROD_W-1:0]    prod_long_s3;
	logic [SUM_OUT_W-1:0] short_s3;
	logic [SUM_OUT_W-1:0] long_s3;
	logic                 ov_q;
	logic                 status_q;
	logic                 buy_q;
	logic                 sell_q;
	logic [SUM_OUT_W-1:0] short_q;
	logic [SUM_OUT_W-1:0] long_q;
	rel_t                 prev_rel_q;
	logic                 prev_valid_q;
	rel_t                 rel;
	logic                 rdy_out;
	logic                 move_s3;

	assign rdy_out  = !ov_q || out_ready;
	assign in_ready = !v_s3 || rdy_out;
	assign move_s3  = v_s3 && rdy_out;

	always_comb begin
		if (prod_short_s3 > prod_long_s3) begin
			rel = REL_ABOVE;
		end else if (prod_short_s3 == prod_long_s3) begin
			rel = REL_EQUAL;
		end else begin
			rel = REL_BELOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3         <= 1'b0;
			ov_q         <= 1'b0;
			prev_rel_q   <= REL_BELOW;
			prev_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s3 <= in_valid;
			end
			if (rdy_out) begin
				ov_q <= v_s3;
			end
			if (restart) begin
				prev_rel_q   <= REL_BELOW;
				prev_valid_q <= 1'b0;
			end else if (move_s3 && status_s3) begin
				prev_rel_q   <= rel;
				prev_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			// short/S against long/L without dividing
			prod_short_s3 <= PROD_W'(in_short_sum) * PROD_W'(eff_long);
			prod_long_s3  <= PROD_W'(in_long_sum) * PROD_W'(eff_short);
			status_s3     <= in_status;
			short_s3      <= SUM_OUT_W'(in_short_sum);
			long_s3       <= SUM_OUT_W'(in_long_sum);
		end
		if (move_s3) begin
			status_q <= status_s3;
			buy_q    <= status_s3 && prev_valid_q && (rel == REL_ABOVE)
				&& (prev_rel_q != REL_ABOVE);
			sell_q   <= status_s3 && prev_valid_q && (rel == REL_BELOW)
				&& (prev_rel_q != REL_BELOW);
			short_q  <= status_s3 ? short_s3 : '0;
			long_q   <= status_s3 ? long_s3 : '0;
		end
	end

	assign out_valid     = ov_q;
	assign out_status    = status_q;
	assign out_buy       = buy_q;
	assign out_sell      = sell_q;
	assign out_short_sum = short_q;
	assign out_long_sum  = long_q;

endmodule

// ===== rtl/core/dual_sma_crossover_detector.sv =====
// top level of the dual moving-average crossover detector
//
//  port group  | role   | payload
//  s_axis_*    | input  | tdata: price
//  m_axis_*    | output | tdata: buy, sell, short_window_sum, long_window_sum;
//              |        | tuser: status
//  cfg_*       | write  | cfg_index selects short_period or long_period
//
// one price per clock unless output stalls; the ring's single write port
// and two read ports, and the running-sum update, set that rate; the compare
// is split into a multiply and a compare stage
// reset clears all control and the sums; ring contents stay undefined and only
// entries written since the last restart are read, so no clearing pass is needed
// each stage holds while the next is full and stalled, so input is still taken
// while a result waits as long as a stage is free
module dual_sma_crossover_detector import dsc_pkg::*; #(
	parameter int MAX_PERIOD  = MAX_PERIOD_DEF,
	parameter int PRICE_WIDTH = PRICE_WIDTH_DEF,
	localparam int IN_DATA_W  = ((PRICE_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // price
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// buy, sell, short_window_sum, long_window_sum, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tuser,   // status
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_WIDTH-1:0]  cfg_wdata
);

	localparam int AW = $clog2(MAX_PERIOD);
	localparam int SW = PRICE_WIDTH + $clog2(MAX_PERIOD + 1);

	logic                   in_fire;
	logic [PRICE_WIDTH-1:0] price;
	logic [AW-1:0]          wr_addr;
	logic [AW-1:0]          rd_addr_short;
	logic [AW-1:0]          rd_addr_long;
	step_ctrl_t             ctrl;
	logic                   restart;
	logic [CFG_WIDTH-1:0]   eff_short;
	logic [CFG_WIDTH-1:0]   eff_long;
	logic [PRICE_WIDTH-1:0] old_short;
	logic [PRICE_WIDTH-1:0] old_long;
	logic                   sum_valid;
	logic                   sum_ready;
	logic                   sum_status;
	logic [SW-1:0]          short_sum;
	logic [SW-1:0]          long_sum;
	logic                   res_buy;
	logic                   res_sell;
	logic [SUM_OUT_W-1:0]   res_short;
	logic [SUM_OUT_W-1:0]   res_long;

	assign price   = s_axis_tdata[PRICE_WIDTH-1:0];
	assign in_fire = s_axis_tvalid && s_axis_tready;

	dsc_front #(
		.MAX_PERIOD(MAX_PERIOD),
		.AW        (AW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_fire      (in_fire),
		.wr_addr      (wr_addr),
		.rd_addr_short(rd_addr_short),
		.rd_addr_long (rd_addr_long),
		.ctrl         (ctrl),
		.restart      (restart),
		.eff_short    (eff_short),
		.eff_long     (eff_long)
	);

	dsc_ring #(
		.DEPTH(MAX_PERIOD),
		.WIDTH(PRICE_WIDTH),
		.AW   (AW)
	) u_ring (
		.clk      (clk),
		.wr_en    (in_fire),
		.wr_addr  (wr_addr),
		.wr_data  (price),
		.rd_en    (in_fire),
		.rd_addr_a(rd_addr_short),
		.rd_addr_b(rd_addr_long),
		.rd_data_a(old_short),
		.rd_data_b(old_long)
	);

	dsc_sums #(
		.PRICE_WIDTH(PRICE_WIDTH),
		.SW         (SW)
	) u_sums (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (restart),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_price     (price),
		.in_ctrl      (ctrl),
		.old_short    (old_short),
		.old_long     (old_long),
		.out_valid    (sum_valid),
		.out_ready    (sum_ready),
		.out_status   (sum_status),
		.out_short_sum(short_sum),
		.out_long_sum (long_sum)
	);

	dsc_cross #(
		.SW(SW)
	) u_cross (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (restart),
		.eff_short    (eff_short),
		.eff_long     (eff_long),
		.in_valid     (sum_valid),
		.in_ready     (sum_ready),
		.in_status    (sum_status),
		.in_short_sum (short_sum),
		.in_long_sum  (long_sum),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_status   (m_axis_tuser),
		.out_buy      (res_buy),
		.out_sell     (res_sell),
		.out_short_sum(res_short),
		.out_long_sum (res_long)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_long, res_short, res_sell, res_buy};

endmodule

// ===== rtl/core/dsc_checker.sv =====
// port-level checker for the crossover detector, bound to the top level
`include "assert_macros.svh"

module dsc_checker import dsc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tuser
);

	logic buy;
	logic sell;
	logic short_zero;
	logic long_zero;

	assign buy        = m_axis_tdata[OUT_BUY_BIT];
	assign sell       = m_axis_tdata[OUT_SELL_BIT];
	assign short_zero = m_axis_tdata[OUT_SHORT_LO +: SUM_OUT_W] == '0;
	assign long_zero  = m_axis_tdata[OUT_LONG_LO +: SUM_OUT_W] == '0;

	// a stalled result transaction keeps its payload
	`DSC_ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// both crossings cannot happen on one item
	`DSC_ASSERT_CLK(a_not_both, m_axis_tvalid |-> !(buy && sell))

	// before the long window fills, every data field is zero
	`DSC_ASSERT_CLK(a_warmup_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)

	// a strictly higher average needs a nonzero sum on that side
	`DSC_ASSERT_CLK(a_cross_sum, m_axis_tvalid |-> (!buy || !short_zero) && (!sell || !long_zero))

endmodule

bind dual_sma_crossover_detector dsc_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

// ===== sim/tb.sv =====
// testbench for the dual moving-average crossover detector: stream stimulus, self-checking
`timescale 1ns / 100ps

module tb;
	import dsc_pkg::*;

	typedef struct packed {
		logic        status;
		logic        buy;
		logic        sell;
		logic [39:0] short_sum;
		logic [39:0] long_sum;
	} signal_t;

	localparam int unsigned EXP_DEPTH = 64;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [31:0]           s_axis_tdata = '0;   // price
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// buy, sell, short_window_sum, long_window_sum, zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;        // status
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_WIDTH-1:0]  cfg_wdata = '0;

	dual_sma_crossover_detector i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	// predictor state
	logic [31:0]          hist_ring [MAX_PERIOD_DEF];
	logic [7:0]           ring_wptr = '0;
	int unsigned          fill_count = 0;
	logic [63:0]          short_acc = '0;
	logic [63:0]          long_acc = '0;
	rel_t                 last_rel = REL_BELOW;
	logic                 last_rel_valid = 1'b0;
	logic [CFG_WIDTH-1:0] cfg_short = SHORT_PERIOD_RST;
	logic [CFG_WIDTH-1:0] cfg_long = LONG_PERIOD_RST;

	// expected results in order, written at input transactions, read at result transactions
	signal_t     exp_fifo [EXP_DEPTH];
	int unsigned exp_wr_cnt = 0;
	int unsigned exp_rd_cnt = 0;
	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned src_idle_pct = 34;
	int unsigned snk_idle_pct = 60;
	logic [31:0] walk_price = 32'h0100_0000;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("dual_sma_crossover_detector test failed");
		$finish;
	end

	task automatic note_failure(input string msg);
		errors++;
		if (errors <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	function automatic int unsigned effective_long();
		if (cfg_long < 1)
			return 1;
		if (cfg_long > MAX_PERIOD_DEF)
			return MAX_PERIOD_DEF;
		return cfg_long;
	endfunction

	function automatic int unsigned effective_short(input int unsigned l);
		if (cfg_short < 1)
			return 1;
		if (cfg_short > l)
			return l;
		return cfg_short;
	endfunction

	task automatic crossover_predict(input logic [31:0] p);
		int unsigned l;
		int unsigned s;
		logic [63:0] prod_s;
		logic [63:0] prod_l;
		rel_t        rel;
		signal_t     sig;
		l = effective_long();
		s = effective_short(l);
		short_acc += p;
		long_acc += p;
		// 8-bit index arithmetic wraps the ring, a period of 256 lands on the write slot
		if (fill_count >= s)
			short_acc -= hist_ring[ring_wptr - 8'(s)];
		if (fill_count >= l)
			long_acc -= hist_ring[ring_wptr - 8'(l)];
		hist_ring[ring_wptr] = p;
		ring_wptr++;
		if (fill_count < l)
			fill_count++;
		sig = '0;
		if (fill_count >= l) begin
			sig.status = 1'b1;
			sig.short_sum = short_acc[39:0];
			sig.long_sum = long_acc[39:0];
			// compare averages without dividing
			prod_s = short_acc * 64'(l);
			prod_l = long_acc * 64'(s);
			rel = (prod_s > prod_l) ? REL_ABOVE : ((prod_s == prod_l) ? REL_EQUAL : REL_BELOW);
			if (last_rel_valid) begin
				sig.buy = (rel == REL_ABOVE) && (last_rel != REL_ABOVE);
				sig.sell = (rel == REL_BELOW) && (last_rel != REL_BELOW);
			end
			last_rel = rel;
			last_rel_valid = 1'b1;
		end
		exp_fifo[exp_wr_cnt % EXP_DEPTH] = sig;
		exp_wr_cnt++;
	endtask

	// result side: random backpressure and in-order compare
	always @(posedge clk) begin
		signal_t got;
		signal_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tuser;
			got.buy = m_axis_tdata[OUT_BUY_BIT];
			got.sell = m_axis_tdata[OUT_SELL_BIT];
			got.short_sum = m_axis_tdata[OUT_SHORT_LO +: SUM_OUT_W];
			got.long_sum = m_axis_tdata[OUT_LONG_LO +: SUM_OUT_W];
			if (exp_wr_cnt == exp_rd_cnt) begin
				note_failure($sformatf("unexpected result transaction: status=%0d buy=%0d sell=%0d",
					got.status, got.buy, got.sell));
			end else begin
				want = exp_fifo[exp_rd_cnt % EXP_DEPTH];
				exp_rd_cnt++;
				if (got.status !== want.status || got.buy !== want.buy || got.sell !== want.sell
						|| got.short_sum !== want.short_sum || got.long_sum !== want.long_sum)
					note_failure($sformatf(
						"mismatch exp st=%0d b=%0d s=%0d ss=%h ls=%h got st=%0d b=%0d s=%0d ss=%h ls=%h",
						want.status, want.buy, want.sell, want.short_sum, want.long_sum,
						got.status, got.buy, got.sell, got.short_sum, got.long_sum));
			end
		end
		m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	task automatic send_price(input logic [31:0] p);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= p;
		do
			@(posedge clk);
		while (!s_axis_tready);
		crossover_predict(p);
		items_sent++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (exp_wr_cnt != exp_rd_cnt)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_WIDTH-1:0] val);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_SHORT_PERIOD)
			cfg_short = val;
		else
			cfg_long = val;
		// any write restarts the windows, ring and write pointer stay
		fill_count = 0;
		short_acc = '0;
		long_acc = '0;
		last_rel = REL_BELOW;
		last_rel_valid = 1'b0;
	endtask

	function automatic logic [31:0] next_price(input int unsigned mode, input int unsigned span);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
			default: begin
				walk_price = walk_price + 32'($urandom_range(0, 2 * span)) - 32'(span);
				return walk_price;
			end
		endcase
	endfunction

	// reset periods: warm-up then valid averages
	task automatic test_reset_periods();
		for (int i = 0; i < 34; i++)
			send_price(next_price(2, 1 << 16));
	endtask

	task automatic test_crossings();
		logic [31:0] seq [10] = '{32'd5, 32'd5, 32'd5, 32'd9, 32'd9, 32'd0, 32'd6,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
		write_reg(REG_SHORT_PERIOD, 9'd1);
		write_reg(REG_LONG_PERIOD, 9'd3);
		foreach (seq[i])
			send_price(seq[i]);
		send_price(32'h0);
	endtask

	task automatic test_period_clamping();
		// zero periods act as one
		write_reg(REG_SHORT_PERIOD, 9'd0);
		write_reg(REG_LONG_PERIOD, 9'd0);
		send_price(32'h0);
		send_price(32'hFFFF_FFFF);
		send_price(32'h7);
		// short above long acts as long
		write_reg(REG_SHORT_PERIOD, 9'd400);
		write_reg(REG_LONG_PERIOD, 9'd2);
		send_price(32'h8000_0000);
		send_price(32'h0000_0001);
		send_price(32'h7FFF_FFFF);
		send_price(32'h1234_5678);
		// rewriting an unchanged value still restarts warm-up
		write_reg(REG_LONG_PERIOD, 9'd2);
		send_price(32'h5555_5555);
		send_price(32'hAAAA_AAAA);
		send_price(32'h0);
	endtask

	task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
			input int unsigned budget);
		int unsigned start;
		int unsigned k;
		int unsigned n;
		int unsigned mode;
		int unsigned span;
		logic [CFG_WIDTH-1:0] lp;
		logic [CFG_WIDTH-1:0] sp;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		start = items_sent;
		while (items_sent - start < budget) begin
			k = $urandom_range(99);
			if (k < 6)
				lp = 9'($urandom_range(256, 511));
			else if (k < 10)
				lp = 9'd0;
			else
				lp = 9'($urandom_range(1, 40));
			k = $urandom_range(99);
			if (k < 10)
				sp = 9'($urandom_range(0, 511));
			else if (k < 15)
				sp = 9'd0;
			else
				sp = 9'($urandom_range(1, (lp == 0) ? 1 : ((lp > 256) ? 256 : lp)));
			k = $urandom_range(99);
			if (k < 15) begin
				write_reg(REG_SHORT_PERIOD, sp);
			end else if (k < 55) begin
				write_reg(REG_LONG_PERIOD, lp);
				write_reg(REG_SHORT_PERIOD, sp);
			end else begin
				write_reg(REG_SHORT_PERIOD, sp);
				write_reg(REG_LONG_PERIOD, lp);
			end
			n = effective_long() + $urandom_range(5, 60);
			mode = $urandom_range(0, 9);
			span = 1 << $urandom_range(4, 24);
			for (int i = 0; i < n; i++)
				send_price(($urandom_range(99) < 5) ? $urandom : next_price(mode, span));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_periods();
		test_crossings();
		test_period_clamping();
		test_random_traffic(34, 60, 300);
		test_random_traffic(60, 34, 300);
		test_random_traffic(0, 0, 300);
		wait_idle();
		if (errors == 0)
			$display("dual_sma_crossover_detector test passed");
		else
			$display("dual_sma_crossover_detector test failed");
		$finish;
	end

endmodule
